>>> rtl/core/ival_pkg.sv
// shared types, widths and operation codes of the integer vector alu
`default_nettype none

package ival_pkg;

    localparam int MAX_LANES          = 4;
    localparam int ELEM_W             = 16;
    localparam int PROD_W             = 2 * ELEM_W;
    localparam int RES_W              = 34;
    localparam int NORM_W             = RES_W;
    localparam int OP_W               = 4;
    localparam int LANE_COUNT_DEF     = 4;
    localparam int ELEMENT_BITS_DEF   = 16;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RES_W-1:0]  res_t;
    typedef logic        [NORM_W-1:0] norm_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_SCALE   = 4'd2,
        OP_DOT     = 4'd3,
        OP_CROSS   = 4'd4,
        OP_INC     = 4'd5,
        OP_DEC     = 4'd6,
        OP_NEG     = 4'd7,
        OP_EQ      = 4'd8,
        OP_LT      = 4'd9,
        OP_GT      = 4'd10,
        OP_LE      = 4'd11,
        OP_GE      = 4'd12,
        OP_NORM_EQ = 4'd13,
        OP_ANY_NZ  = 4'd14,
        OP_ZERO    = 4'd15
    } op_t;

    // what one lane hands to the merging stage
    typedef struct packed {
        res_t  vec;
        prod_t ab;
        prod_t aa;
        prod_t bb;
        prod_t xp;
        prod_t xq;
        logic  eq;
    } lane_out_t;

    // merged sums, ready for the flag compare
    typedef struct packed {
        op_t                     op;
        res_t [MAX_LANES-1:0]    vec;
        res_t                    dot;
        norm_t                   na;
        norm_t                   nb;
        logic                    eq_all;
    } merge_t;

    typedef struct packed {
        res_t [MAX_LANES-1:0] vec;
        res_t                 scalar;
        logic                 flag;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/ival_lane.sv
// one vector lane: lane-wise ops, products for dot, norms and cross product
`default_nettype none

module ival_lane import ival_pkg::*; (
    input  op_t       op,
    input  elem_t     a,
    input  elem_t     b,
    input  elem_t     k,
    input  elem_t     nxt_a,
    input  elem_t     nxt_b,
    input  elem_t     far_a,
    input  elem_t     far_b,
    output lane_out_t y
);

    res_t  ax;
    res_t  bx;
    prod_t scaled;

    always_comb begin
        ax     = RES_W'(a);
        bx     = RES_W'(b);
        scaled = PROD_W'(k) * PROD_W'(a);

        case (op)
            OP_ADD:   y.vec = ax + bx;
            OP_SUB:   y.vec = ax - bx;
            OP_SCALE: y.vec = RES_W'(scaled);
            OP_INC:   y.vec = ax + RES_W'(1);
            OP_DEC:   y.vec = ax - RES_W'(1);
            OP_NEG:   y.vec = -ax;
            default:  y.vec = '0;
        endcase

        y.ab = PROD_W'(a) * PROD_W'(b);
        y.aa = PROD_W'(a) * PROD_W'(a);
        y.bb = PROD_W'(b) * PROD_W'(b);
        // cross terms, difference taken in the merge stage
        y.xp = PROD_W'(nxt_a) * PROD_W'(far_b);
        y.xq = PROD_W'(nxt_b) * PROD_W'(far_a);
        y.eq = (a == b);
    end

endmodule

`default_nettype wire

>>> rtl/core/ival_merge.sv
// merging stage: dot and norm sums, cross differences, lane equality
`default_nettype none

module ival_merge import ival_pkg::*; (
    input  op_t                       op,
    input  lane_out_t [MAX_LANES-1:0] lanes,
    output merge_t                    y
);

    always_comb begin
        y.op     = op;
        y.dot    = '0;
        y.na     = '0;
        y.nb     = '0;
        y.eq_all = 1'b1;
        for (int i = 0; i < MAX_LANES; i++) begin
            y.dot    = y.dot + RES_W'(lanes[i].ab);
            y.na     = y.na + NORM_W'($unsigned(lanes[i].aa));
            y.nb     = y.nb + NORM_W'($unsigned(lanes[i].bb));
            y.eq_all = y.eq_all & lanes[i].eq;
            if (op == OP_CROSS) begin
                y.vec[i] = RES_W'(lanes[i].xp) - RES_W'(lanes[i].xq);
            end else begin
                y.vec[i] = lanes[i].vec;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ival_select.sv
// final stage: norm compares, flag and scalar selection
`default_nettype none

module ival_select import ival_pkg::*; (
    input  merge_t  x,
    output result_t y
);

    logic na_zero;
    logic nb_zero;

    always_comb begin
        na_zero  = (x.na == '0);
        nb_zero  = (x.nb == '0);
        y.vec    = x.vec;
        y.scalar = (x.op == OP_DOT) ? x.dot : '0;
        case (x.op)
            OP_EQ:      y.flag = x.eq_all;
            OP_LT:      y.flag = (x.na < x.nb);
            OP_GT:      y.flag = (x.na > x.nb);
            OP_LE:      y.flag = (x.na <= x.nb);
            OP_GE:      y.flag = (x.na >= x.nb);
            OP_NORM_EQ: y.flag = (x.na == x.nb) && !na_zero;
            OP_ANY_NZ:  y.flag = !na_zero || !nb_zero;
            OP_ZERO:    y.flag = na_zero;
            default:    y.flag = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/integer_vector_alu.sv
// top level of the four-lane signed integer vector alu
`default_nettype none

// integer_vector_alu takes one item per cycle on the s_ stream while s_tready is high: two
// signed vectors, a scalar and an operation code in s_tuser, and returns one result item on
// the m_ stream. vector ops (add, sub, scale, inc, dec, neg, cross) fill result_lane0..3, dot
// fills scalar_result, equality and squared-norm tests set test_flag; unused fields are zero.
// results are 34 bits signed and never overflow. the block sustains one item per cycle while
// m_tready does not stall it, through lane multipliers, then the merging adder stage, then
// the compare and output register. each stage has its own valid bit, so a stalled result
// only holds back the stages behind it. LANE_COUNT (3 or 4) sets the active lanes,
// ELEMENT_BITS (8..16) the element width taken from the low bits of each field.

module integer_vector_alu import ival_pkg::*; #(
    parameter int LANE_COUNT   = LANE_COUNT_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input items
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // first_lane0..3, second_lane0..3, scale_factor, 16 bits each
    input  wire logic [143:0] s_tdata,
    // operation
    input  wire logic [3:0]   s_tuser,
    // result items
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // result_lane0..3, scalar_result (34 bits each), test_flag, zero pad
    output      logic [175:0] m_tdata
);

    localparam int PAD_W = 176 - (MAX_LANES + 1) * RES_W - 1;

    // parameters held to their legal ranges
    localparam int LANES_USED =
        (LANE_COUNT < 3) ? 3 : ((LANE_COUNT > MAX_LANES) ? MAX_LANES : LANE_COUNT);
    localparam int ELEM_BITS_USED =
        (ELEMENT_BITS < 8) ? 8 : ((ELEMENT_BITS > ELEM_W) ? ELEM_W : ELEMENT_BITS);

    // elements sign-extended from ELEMENT_BITS
    elem_t [MAX_LANES-1:0] a_el;
    elem_t [MAX_LANES-1:0] b_el;
    elem_t                 k_el;
    op_t                   in_op;

    lane_out_t [MAX_LANES-1:0] lane_y;
    merge_t                    merge_y;
    result_t                   sel_y;

    // pipeline registers
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s2_valid_reg, s2_valid_next;
    logic                      out_valid_reg, out_valid_next;
    op_t                       s1_op_reg;
    lane_out_t [MAX_LANES-1:0] s1_lanes_reg;
    merge_t                    s2_reg;
    result_t                   out_reg;

    // per-stage ready, each stage moves when the one ahead can take it
    logic out_ready;
    logic s2_ready;
    logic s1_ready;

    assign in_op = op_t'(s_tuser);
    assign k_el  = ELEM_W'($signed(s_tdata[2*MAX_LANES*ELEM_W +: ELEM_BITS_USED]));

    for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
        assign a_el[i] = ELEM_W'($signed(s_tdata[i*ELEM_W +: ELEM_BITS_USED]));
        assign b_el[i] = ELEM_W'($signed(s_tdata[(MAX_LANES+i)*ELEM_W +: ELEM_BITS_USED]));

        if (i < LANES_USED) begin : g_active
            elem_t nxt_a, nxt_b, far_a, far_b;
            // cross product always runs on lanes 0..2
            if (i < 3) begin : g_cross
                assign nxt_a = a_el[(i+1)%3];
                assign nxt_b = b_el[(i+1)%3];
                assign far_a = a_el[(i+2)%3];
                assign far_b = b_el[(i+2)%3];
            end else begin : g_no_cross
                assign nxt_a = '0;
                assign nxt_b = '0;
                assign far_a = '0;
                assign far_b = '0;
            end

            ival_lane u_lane (
                .op    (in_op),
                .a     (a_el[i]),
                .b     (b_el[i]),
                .k     (k_el),
                .nxt_a (nxt_a),
                .nxt_b (nxt_b),
                .far_a (far_a),
                .far_b (far_b),
                .y     (lane_y[i])
            );
        end else begin : g_idle
            // inactive lane adds nothing and never breaks equality
            assign lane_y[i] = '{vec: '0, ab: '0, aa: '0, bb: '0, xp: '0, xq: '0, eq: 1'b1};
        end
    end

    ival_merge u_merge (
        .op    (s1_op_reg),
        .lanes (s1_lanes_reg),
        .y     (merge_y)
    );

    ival_select u_select (
        .x (s2_reg),
        .y (sel_y)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;

    always_comb begin
        s1_valid_next  = s1_ready  ? s_tvalid     : s1_valid_reg;
        s2_valid_next  = s2_ready  ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_op_reg    <= in_op;
            s1_lanes_reg <= lane_y;
        end
        if (s2_ready) begin
            s2_reg <= merge_y;
        end
        if (out_ready) begin
            out_reg <= sel_y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_reg.flag, out_reg.scalar, out_reg.vec};

endmodule

`default_nettype wire
